// ===== rtl/lgr_pkg.sv =====
// Shared types and constants for the linear gain ramp block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lgr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int FRAMES_W  = 24;
    localparam int PROD_W    = FRAMES_W + GAIN_W;
    localparam int DIV_STEPS = GAIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [GAIN_W-1:0]   UNITY_GAIN   = 16'h8000;
    localparam logic [FRAMES_W-1:0] ELAPSED_MAX  = 24'hFFFFFF;
    localparam logic [FRAMES_W-1:0] RAMP_DEFAULT = 24'd48000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic        [GAIN_W-1:0]   target_level;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic        [GAIN_W-1:0]   gain_now;
    } out_word_t;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   dividend;
        logic [FRAMES_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/lgr_div.sv =====
// Restoring divider, one quotient bit per cycle, for the ramp offset.
// Depends on lgr_pkg; the caller guarantees the quotient fits in GAIN_W bits.
`timescale 1ns / 1ps

module lgr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  lgr_pkg::div_req_t req,
    output lgr_pkg::div_rsp_t rsp
);

    logic [lgr_pkg::FRAMES_W-1:0]  rem_reg, rem_next;
    logic [lgr_pkg::GAIN_W-1:0]    low_reg, low_next;
    logic [lgr_pkg::GAIN_W-1:0]    quo_reg, quo_next;
    logic [lgr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [lgr_pkg::FRAMES_W:0]    trial;
    logic [lgr_pkg::FRAMES_W:0]    diff;

    assign trial = {rem_reg, low_reg[lgr_pkg::GAIN_W-1]};
    assign diff  = trial - {1'b0, req.divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            // upper bits are already below the divisor
            rem_next = req.dividend[lgr_pkg::PROD_W-1:lgr_pkg::GAIN_W];
            low_next = req.dividend[lgr_pkg::GAIN_W-1:0];
            quo_next = '0;
            cnt_next = lgr_pkg::DIV_CNT_W'(lgr_pkg::DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            low_next = {low_reg[lgr_pkg::GAIN_W-2:0], 1'b0};
            if (!diff[lgr_pkg::FRAMES_W])
            begin
                rem_next = diff[lgr_pkg::FRAMES_W-1:0];
                quo_next = {quo_reg[lgr_pkg::GAIN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[lgr_pkg::FRAMES_W-1:0];
                quo_next = {quo_reg[lgr_pkg::GAIN_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == lgr_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/linear_gain_ramp_top.sv =====
// Top level of the linear gain ramp: sequencer, shared multiplier, ramp state.
// Depends on lgr_pkg and lgr_div.
`timescale 1ns / 1ps
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    in_data  (lgr_pkg::in_word_t)
//  out      out  out_valid/out_ready  out_data (lgr_pkg::out_word_t)
//  cfg      in   cfg_wr_en            cfg_wr_data[23:0] = ramp_frames
//
//  A frame with a ramp running goes from accept to result through one 24x16
//  multiply, the bit-serial divider, then two sample multiplies on the same
//  multiplier. A frame at steady gain, or with a zero ramp length, skips the
//  ramp multiply and the divider. The result sits in an output register, so a
//  stalled output only holds the sequencer when the next result is ready.
//  Reset gives unity gain, no ramp, and a ramp length of 48000 frames.

module linear_gain_ramp_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lgr_pkg::in_word_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lgr_pkg::out_word_t           out_data,
    input  logic                         cfg_wr_en,
    input  logic [lgr_pkg::FRAMES_W-1:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_MUL, S_DIVGO, S_DIVW, S_SCL_L, S_SCL_R, S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [lgr_pkg::FRAMES_W-1:0] rf_reg, rf_next;
    logic [lgr_pkg::GAIN_W-1:0]   cur_reg, cur_next;
    logic [lgr_pkg::GAIN_W-1:0]   start_reg, start_next;
    logic [lgr_pkg::GAIN_W-1:0]   tgt_reg, tgt_next;
    logic [lgr_pkg::FRAMES_W-1:0] elapsed_reg, elapsed_next;

    logic signed [lgr_pkg::SAMPLE_W-1:0] left_reg, left_next;
    logic signed [lgr_pkg::SAMPLE_W-1:0] right_reg, right_next;
    logic [lgr_pkg::GAIN_W-1:0]          req_reg, req_next;
    logic                                up_reg, up_next;
    logic [lgr_pkg::PROD_W-1:0]          prod_reg, prod_next;
    logic signed [lgr_pkg::SAMPLE_W-1:0] lres_reg, lres_next;
    logic                                ovalid_reg, ovalid_next;
    lgr_pkg::out_word_t                  odata_reg, odata_next;

    logic [lgr_pkg::FRAMES_W-1:0] mul_a;
    logic [lgr_pkg::GAIN_W-1:0]   mul_b;
    logic [lgr_pkg::PROD_W-1:0]   mul_p;

    lgr_pkg::div_req_t div_req;
    lgr_pkg::div_rsp_t div_rsp;

    lgr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign div_req.start    = (state_reg == S_DIVGO);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = rf_reg;

    function automatic logic [lgr_pkg::GAIN_W-1:0] magnitude(
        input logic signed [lgr_pkg::SAMPLE_W-1:0] s
    );
        logic [lgr_pkg::GAIN_W-1:0] u;
        u = lgr_pkg::GAIN_W'(s);
        return s[lgr_pkg::SAMPLE_W-1] ? (~u + 1'b1) : u;
    endfunction

    // product >> 15, sign restored, truncated to the sample width
    function automatic logic signed [lgr_pkg::SAMPLE_W-1:0] rescale(
        input logic [lgr_pkg::PROD_W-1:0] p,
        input logic                       neg
    );
        logic [lgr_pkg::SAMPLE_W-1:0] q;
        q = p[lgr_pkg::GAIN_W+lgr_pkg::SAMPLE_W-2:lgr_pkg::GAIN_W-1];
        return neg ? $signed(~q + 1'b1) : $signed(q);
    endfunction

    function automatic logic [lgr_pkg::FRAMES_W-1:0] sat_inc(
        input logic [lgr_pkg::FRAMES_W-1:0] v
    );
        return (v == lgr_pkg::ELAPSED_MAX) ? v : v + 1'b1;
    endfunction

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL:
            begin
                mul_a = (elapsed_reg < rf_reg) ? elapsed_reg : rf_reg;
                mul_b = up_reg ? (tgt_reg - start_reg) : (start_reg - tgt_reg);
            end
            S_SCL_L:
            begin
                mul_a = lgr_pkg::FRAMES_W'(magnitude(left_reg));
                mul_b = cur_reg;
            end
            S_SCL_R:
            begin
                mul_a = lgr_pkg::FRAMES_W'(magnitude(right_reg));
                mul_b = cur_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = lgr_pkg::PROD_W'(mul_a) * lgr_pkg::PROD_W'(mul_b);

    always_comb
    begin
        logic                          new_ramp;
        logic [lgr_pkg::FRAMES_W-1:0] base;
        state_next   = state_reg;
        rf_next      = rf_reg;
        cur_next     = cur_reg;
        start_next   = start_reg;
        tgt_next     = tgt_reg;
        elapsed_next = elapsed_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        req_next     = req_reg;
        up_next      = up_reg;
        prod_next    = prod_reg;
        lres_next    = lres_reg;
        ovalid_next  = ovalid_reg;
        odata_next   = odata_reg;
        new_ramp     = (tgt_reg != req_reg);
        base         = new_ramp ? '0 : elapsed_reg;

        if (cfg_wr_en)
            rf_next = cfg_wr_data;

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    left_next  = in_data.left_in;
                    right_next = in_data.right_in;
                    req_next   = (in_data.target_level > lgr_pkg::UNITY_GAIN) ?
                                 lgr_pkg::UNITY_GAIN : in_data.target_level;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (cur_reg != req_reg)
                begin
                    if (new_ramp)
                    begin
                        tgt_next   = req_reg;
                        start_next = cur_reg;
                    end
                    if (rf_reg == '0)
                    begin
                        cur_next     = req_reg;
                        elapsed_next = sat_inc(base);
                        state_next   = S_SCL_L;
                    end
                    else
                    begin
                        elapsed_next = base;
                        up_next      = new_ramp ? (req_reg >= cur_reg) :
                                                  (tgt_reg >= start_reg);
                        state_next   = S_MUL;
                    end
                end
                else
                begin
                    tgt_next   = cur_reg;
                    start_next = cur_reg;
                    state_next = S_SCL_L;
                end
            end
            S_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_DIVGO;
            end
            S_DIVGO:
                state_next = S_DIVW;
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    cur_next     = up_reg ? (start_reg + div_rsp.quotient) :
                                            (start_reg - div_rsp.quotient);
                    elapsed_next = sat_inc(elapsed_reg);
                    state_next   = S_SCL_L;
                end
            end
            S_SCL_L:
            begin
                prod_next  = mul_p;
                state_next = S_SCL_R;
            end
            S_SCL_R:
            begin
                lres_next  = rescale(prod_reg, left_reg[lgr_pkg::SAMPLE_W-1]);
                prod_next  = mul_p;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    odata_next.left_out  = lres_reg;
                    odata_next.right_out = rescale(prod_reg,
                                                   right_reg[lgr_pkg::SAMPLE_W-1]);
                    odata_next.gain_now  = cur_reg;
                    ovalid_next          = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rf_reg      <= lgr_pkg::RAMP_DEFAULT;
            cur_reg     <= lgr_pkg::UNITY_GAIN;
            start_reg   <= lgr_pkg::UNITY_GAIN;
            tgt_reg     <= lgr_pkg::UNITY_GAIN;
            elapsed_reg <= '0;
            ovalid_reg  <= 1'b0;
            odata_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rf_reg      <= rf_next;
            cur_reg     <= cur_next;
            start_reg   <= start_next;
            tgt_reg     <= tgt_next;
            elapsed_reg <= elapsed_next;
            ovalid_reg  <= ovalid_next;
            odata_reg   <= odata_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        req_reg   <= req_next;
        up_reg    <= up_next;
        prod_reg  <= prod_next;
        lres_reg  <= lres_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

endmodule

// ===== rtl/lgr_checker.sv =====
// Port-level checks for linear_gain_ramp_top, attached by bind.
// Depends on lgr_pkg and linear_gain_ramp_top.
`timescale 1ns / 1ps

module lgr_port_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input lgr_pkg::out_word_t out_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // one frame at a time: no accept in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on back-to-back cycles");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.gain_now <= lgr_pkg::UNITY_GAIN)
        else $error("gain above unity");

    a_mute: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.gain_now == '0 |->
            out_data.left_out == '0 && out_data.right_out == '0)
        else $error("nonzero sample at zero gain");

endmodule

bind linear_gain_ramp_top lgr_port_checker u_lgr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== dv/lgr_checker.sv =====
// Scoreboard for the linear gain ramp: tracks the ramp state from accepted words,
// predicts each output word and compares it field by field. Depends on lgr_pkg.
`timescale 1ns / 1ps

module lgr_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  lgr_pkg::in_word_t            in_data,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  lgr_pkg::out_word_t           out_data,
    input  logic                         cfg_wr_en,
    input  logic [lgr_pkg::FRAMES_W-1:0] cfg_wr_data,
    output int                           fail_count,
    output int                           frames_pending
);

    logic [lgr_pkg::FRAMES_W-1:0] ramp_len;
    logic [lgr_pkg::GAIN_W-1:0]   gain_cur;
    logic [lgr_pkg::GAIN_W-1:0]   ramp_from;
    logic [lgr_pkg::GAIN_W-1:0]   ramp_to;
    logic [lgr_pkg::FRAMES_W-1:0] frames_done;
    lgr_pkg::out_word_t           scaled_frames[$];
    lgr_pkg::out_word_t           want;

    function automatic logic [lgr_pkg::GAIN_W-1:0] ramp_point();
        logic [lgr_pkg::FRAMES_W-1:0] e;
        logic [63:0]                  offset;
        if (ramp_len == '0)
            return ramp_to;
        e = (frames_done < ramp_len) ? frames_done : ramp_len;
        // offset is truncated toward zero, so the ramp never overshoots
        if (ramp_to >= ramp_from)
        begin
            offset = (64'(ramp_to - ramp_from) * 64'(e)) / 64'(ramp_len);
            return ramp_from + offset[lgr_pkg::GAIN_W-1:0];
        end
        offset = (64'(ramp_from - ramp_to) * 64'(e)) / 64'(ramp_len);
        return ramp_from - offset[lgr_pkg::GAIN_W-1:0];
    endfunction

    function automatic logic [lgr_pkg::SAMPLE_W-1:0] scaled_sample(
        input logic signed [lgr_pkg::SAMPLE_W-1:0] s,
        input logic [lgr_pkg::GAIN_W-1:0]          g
    );
        logic [lgr_pkg::SAMPLE_W:0]                 mag;
        logic [lgr_pkg::SAMPLE_W+lgr_pkg::GAIN_W:0] prod;
        logic [lgr_pkg::SAMPLE_W-1:0]               q;
        // magnitude times gain, truncated toward zero, sign put back
        mag  = s[lgr_pkg::SAMPLE_W-1] ? (17'd0 - {s[lgr_pkg::SAMPLE_W-1], s}) :
                                        {1'b0, s};
        prod = mag * g;
        q    = prod[lgr_pkg::SAMPLE_W+14:15];
        return s[lgr_pkg::SAMPLE_W-1] ? (16'd0 - q) : q;
    endfunction

    function automatic lgr_pkg::out_word_t apply_gain_ramp(input lgr_pkg::in_word_t w);
        logic [lgr_pkg::GAIN_W-1:0] req;
        lgr_pkg::out_word_t         r;
        req = (w.target_level > lgr_pkg::UNITY_GAIN) ? lgr_pkg::UNITY_GAIN :
                                                       w.target_level;
        if (gain_cur != req)
        begin
            if (ramp_to != req)
            begin
                ramp_to     = req;
                ramp_from   = gain_cur;
                frames_done = '0;
            end
            gain_cur = ramp_point();
            if (frames_done != lgr_pkg::ELAPSED_MAX)
                frames_done = frames_done + 1'b1;
        end
        else
        begin
            ramp_to   = gain_cur;
            ramp_from = gain_cur;
        end
        r.left_out  = scaled_sample(w.left_in, gain_cur);
        r.right_out = scaled_sample(w.right_in, gain_cur);
        r.gain_now  = gain_cur;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_len       = lgr_pkg::RAMP_DEFAULT;
            gain_cur       = lgr_pkg::UNITY_GAIN;
            ramp_from      = lgr_pkg::UNITY_GAIN;
            ramp_to        = lgr_pkg::UNITY_GAIN;
            frames_done    = '0;
            scaled_frames.delete();
            fail_count     = 0;
            frames_pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
                ramp_len = cfg_wr_data;
            // output first: a word accepted on this edge cannot be the result of this edge's input
            if (out_valid && out_ready)
            begin
                if (scaled_frames.size() == 0)
                begin
                    $error("output word %h with nothing outstanding", out_data);
                    fail_count++;
                end
                else
                begin
                    want = scaled_frames.pop_front();
                    if (out_data.left_out !== want.left_out)
                    begin
                        $error("left_out: expected %0d, actual %0d",
                               want.left_out, out_data.left_out);
                        fail_count++;
                    end
                    if (out_data.right_out !== want.right_out)
                    begin
                        $error("right_out: expected %0d, actual %0d",
                               want.right_out, out_data.right_out);
                        fail_count++;
                    end
                    if (out_data.gain_now !== want.gain_now)
                    begin
                        $error("gain_now: expected %0d, actual %0d",
                               want.gain_now, out_data.gain_now);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                scaled_frames.push_back(apply_gain_ramp(in_data));
            frames_pending = scaled_frames.size();
        end
    end

endmodule

// ===== dv/tb_linear_gain_ramp_top.sv =====
// Testbench top for linear_gain_ramp_top: clock, reset, word stimulus, ramp length
// writes, random idling and the verdict. Depends on lgr_pkg and lgr_checker.
`timescale 1ns / 1ps

module tb_linear_gain_ramp_top;

    localparam int STUCK_LIMIT = 1000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 210;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         in_ready;
    lgr_pkg::in_word_t            in_data     = '0;
    logic                         out_valid;
    logic                         out_ready   = 1'b0;
    lgr_pkg::out_word_t           out_data;
    logic                         cfg_wr_en   = 1'b0;
    logic [lgr_pkg::FRAMES_W-1:0] cfg_wr_data = '0;

    int                           fail_count;
    int                           frames_pending;
    int                           gap_pct     = 0;
    int                           stall_pct   = 0;
    int                           stuck_cycles;
    logic [lgr_pkg::GAIN_W-1:0]   last_level  = lgr_pkg::UNITY_GAIN;
    logic [lgr_pkg::GAIN_W-1:0]   older_level = lgr_pkg::UNITY_GAIN;
    logic [lgr_pkg::FRAMES_W-1:0] ramp_plan [PHASES];

    always #6 clk = ~clk;

    linear_gain_ramp_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    lgr_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .fail_count     (fail_count),
        .frames_pending (frames_pending)
    );

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic push_frame(input lgr_pkg::in_word_t w);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_words(
        input logic signed [lgr_pkg::SAMPLE_W-1:0] l,
        input logic signed [lgr_pkg::SAMPLE_W-1:0] r,
        input logic [lgr_pkg::GAIN_W-1:0]          level
    );
        lgr_pkg::in_word_t w;
        w.left_in      = l;
        w.right_in     = r;
        w.target_level = level;
        push_frame(w);
    endtask

    // block must be idle before the ramp length changes
    task automatic settle();
        in_valid <= 1'b0;
        while (frames_pending != 0)
            @(negedge clk);
    endtask

    task automatic set_ramp_len(input logic [lgr_pkg::FRAMES_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [lgr_pkg::SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            return lgr_pkg::SAMPLE_W'($urandom);
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // mostly legal gains; some above unity, some returning to an older request
    function automatic logic [lgr_pkg::GAIN_W-1:0] pick_level();
        logic [lgr_pkg::GAIN_W-1:0] v;
        int                         sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            v = lgr_pkg::GAIN_W'($urandom_range(0, 32768));
        else if (sel < 63)
            v = '0;
        else if (sel < 73)
            v = lgr_pkg::UNITY_GAIN;
        else if (sel < 80)
            v = lgr_pkg::GAIN_W'($urandom_range(32769, 65535));
        else if (sel < 90)
            v = older_level;
        else
            v = last_level;
        older_level = last_level;
        last_level  = v;
        return v;
    endfunction

    initial
    begin : out_stall
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                hold = $urandom_range(1, 4) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int                         sent;
        int                         seg;
        int                         k;
        logic [lgr_pkg::GAIN_W-1:0] level;
        logic [lgr_pkg::GAIN_W-1:0] lvl_k;

        ramp_plan[0] = 24'd1;
        ramp_plan[1] = 24'd0;
        ramp_plan[2] = lgr_pkg::FRAMES_W'($urandom_range(3, 16));
        ramp_plan[3] = lgr_pkg::ELAPSED_MAX;
        ramp_plan[4] = 24'd2;
        ramp_plan[5] = lgr_pkg::FRAMES_W'($urandom_range(17, 64));
        ramp_plan[6] = lgr_pkg::RAMP_DEFAULT;
        ramp_plan[7] = lgr_pkg::FRAMES_W'($urandom_range(3, 8));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gap_pct   = 30;
        stall_pct = 30;

        // reset ramp length: steady unity, requests above unity, a slow ramp start
        send_words(16'sd32767, -16'sd32768, lgr_pkg::UNITY_GAIN);
        send_words(-16'sd32768, 16'sd32767, lgr_pkg::UNITY_GAIN);
        send_words(16'sd0, -16'sd1, 16'hFFFF);
        send_words(16'sd1, -16'sd2, 16'd32769);
        send_words(16'sd32767, 16'sd32767, 16'd16384);
        send_words(16'sd32767, -16'sd32768, 16'd16384);
        send_words(-16'sd32768, -16'sd32768, lgr_pkg::UNITY_GAIN);

        // zero length: the gain jumps in the same frame
        settle();
        set_ramp_len('0);
        send_words(-16'sd32768, 16'sd32767, 16'd0);
        send_words(16'sd12345, -16'sd12345, 16'd16384);
        send_words(-16'sd32768, -16'sd1, 16'd40000);
        send_words(-16'sd1, 16'sd1, 16'd1);

        // short ramp with uneven steps, a restart mid-ramp and a request at the current gain
        settle();
        set_ramp_len(24'd3);
        repeat (4) send_words(-16'sd32768, 16'sd32767, lgr_pkg::UNITY_GAIN);
        send_words(16'sd32767, -16'sd32768, 16'd0);
        send_words(16'sd20001, -16'sd20001, 16'd0);
        send_words(-16'sd7, 16'sd7, 16'd20000);
        send_words(16'sd32767, -16'sd1, 16'd20000);
        send_words(-16'sd32768, 16'sd100, 16'd21231);
        send_words(16'sd5, -16'sd5, 16'hFFFF);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            set_ramp_len(ramp_plan[p]);
            if (p == 3 || p == PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = $urandom_range(10, 50);
                stall_pct = $urandom_range(10, 50);
            end
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                level = pick_level();
                // hold a request for a random run of words; for short ramps the run can outlast the ramp
                if (ramp_plan[p] <= 24'd64)
                    seg = $urandom_range(1, int'(ramp_plan[p]) * 2 + 4);
                else
                    seg = $urandom_range(1, 60);
                for (k = 0; k < seg && sent < PHASE_WORDS; k++)
                begin
                    lvl_k = ($urandom_range(0, 19) == 0) ?
                            lgr_pkg::GAIN_W'($urandom) : level;
                    send_words(pick_sample(), pick_sample(), lvl_k);
                    sent++;
                end
            end
        end

        settle();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && frames_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lgr_pkg.sv
rtl/lgr_div.sv
rtl/linear_gain_ramp_top.sv
rtl/lgr_checker.sv
dv/lgr_checker.sv
dv/tb_linear_gain_ramp_top.sv
